// ----- hdl/cmi_pkg.sv -----
// ----------------------------------------------------------------------------
// Choppy market index package
// Shared types and constants for the choppy market index block: request and
// result payloads, the sequencer state type and the fixed scaling constants.
// ----------------------------------------------------------------------------
package cmi_pkg;

	// Width of each price field on the request channel.
	localparam int unsigned PRICE_FIELD_BITS = 32;
	// Width of the index field of a result.
	localparam int unsigned INDEX_BITS = 24;
	// Width of the configuration data bus.
	localparam int unsigned CFG_DATA_BITS = 32;
	// Width of the configuration address bus (one register, one spare slot).
	localparam int unsigned CFG_ADDR_BITS = 3;
	// Width of the window length register.
	localparam int unsigned WINDOW_BITS = 6;
	// Reset value of the window length register.
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 6'd14;
	// Register index of the window length register.
	localparam logic [0:0] REG_WINDOW = 1'b0;

	// 100 percent in units of 1/256.
	localparam int unsigned SCALE_BITS = 15;
	localparam logic [SCALE_BITS-1:0] SCALE_NUM = 15'd25600;
	// Largest index value; larger quotients saturate here.
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

	// One price bar.
	typedef struct packed {
		logic [PRICE_FIELD_BITS-1:0] bar_high;
		logic [PRICE_FIELD_BITS-1:0] bar_low;
		logic [PRICE_FIELD_BITS-1:0] bar_close;
	} bar_t;

	// One result.
	typedef struct packed {
		logic [INDEX_BITS-1:0] index_value;
		logic                  ready_res;
	} result_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_CHECK,
		ST_MUL,
		ST_SAT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/cmi_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module cmi_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/choppy_market_index.sv -----
// ----------------------------------------------------------------------------
// Choppy market index
// Keeps a ring of recent price bars and reports 100 * |close - earlier close|
// divided by the high-low range of the window, in units of 1/256.
// ----------------------------------------------------------------------------
// Each accepted bar is written into a history RAM and yields exactly one
// result. Until the history holds HISTORY_DEPTH bars (or when window_length is
// not below HISTORY_DEPTH), and whenever window_length is zero, the history
// walk is skipped and the result is registered with a zero index. For a zero
// index, only ready_res can be set. Once ready, the block reads one older bar
// per cycle from the history RAM to find the window high, low and earlier
// close. It then scales the close difference by one constant multiply and
// runs a 24-step restoring divider. A saturated quotient skips the divider.
// A flat or inverted range also skips the multiply. bar_ready rises in the
// same cycle as result_valid. A result that waits on the result channel
// stalls the next request. Prices are kept in their low PRICE_BITS bits (at
// most 32). window_length sits at address 0 of the register port and must
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module choppy_market_index #(
	parameter int unsigned HISTORY_DEPTH = 64,
	parameter int unsigned PRICE_BITS    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                bar_valid,
	output logic                                bar_ready,
	input  cmi_pkg::bar_t                       bar,
	// Result channel.
	output logic                                result_valid,
	input  logic                                result_ready,
	output cmi_pkg::result_t                    result,
	// Register port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cmi_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [cmi_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [cmi_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int unsigned SW  = (PRICE_BITS < cmi_pkg::PRICE_FIELD_BITS) ?
		PRICE_BITS : cmi_pkg::PRICE_FIELD_BITS;
	localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned IB  = cmi_pkg::INDEX_BITS;
	localparam int unsigned WB  = cmi_pkg::WINDOW_BITS;
	localparam int unsigned NW  = SW + IB;
	localparam int unsigned RW  = 3 * SW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	cmi_pkg::state_t state_q, state_d;

	// Control registers.
	logic [WB-1:0]   window_q;
	logic [AW-1:0]   wr_slot_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   bars_seen_q;
	logic [WB:0]     iss_age_q;
	logic            pend_q;
	logic [4:0]      cnt_q;
	logic            result_valid_q;

	// Payload registers.
	logic [WB-1:0]   pend_age_q;
	logic [SW-1:0]   hh_q;
	logic [SW-1:0]   ll_q;
	logic [SW-1:0]   cnow_q;
	logic [SW-1:0]   cold_q;
	logic [SW-1:0]   range_q;
	logic [SW-1:0]   diff_q;
	logic [NW-1:0]   num_q;
	logic [SW-1:0]   rem_q;
	logic [IB-1:0]   quo_q;
	logic [IB-1:0]   res_idx_q;
	logic            res_rdy_q;
	cmi_pkg::result_t result_q;

	// Combinational control.
	logic            bar_acc;
	logic            issue;
	logic            out_load;
	logic            hist_ready;
	logic            range_pos;
	logic            sat;
	logic            div_last;
	logic            cfg_wr;

	// RAM signals.
	logic [RW-1:0]   ram_wdata;
	logic [RW-1:0]   ram_rdata;
	logic [SW-1:0]   rd_high;
	logic [SW-1:0]   rd_low;
	logic [SW-1:0]   rd_close;

	// Divider step.
	logic [SW:0]     rem_sh;
	logic [SW:0]     rem_sub;
	logic            rem_ge;
	logic            q_bit;

	// History RAM holding {high, low, close} per slot.
	assign ram_wdata = {bar.bar_high[SW-1:0], bar.bar_low[SW-1:0], bar.bar_close[SW-1:0]};
	assign rd_high   = ram_rdata[3*SW-1:2*SW];
	assign rd_low    = ram_rdata[2*SW-1:SW];
	assign rd_close  = ram_rdata[SW-1:0];

	cmi_ram #(
		.WIDTH (RW),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (bar_acc),
		.waddr (wr_slot_q),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Status terms used by the sequencer.
	assign hist_ready = (bars_seen_q == CW'(HISTORY_DEPTH)) &&
		(32'(window_q) < 32'(HISTORY_DEPTH));
	assign range_pos  = hh_q > ll_q;
	assign sat        = num_q >= {range_q, {IB{1'b0}}};
	assign div_last   = cnt_q == 5'(IB - 1);

	// One restoring division step on the divider's subtractor.
	assign rem_sh  = {rem_q, quo_q[IB-1]};
	assign rem_ge  = rem_sh >= {1'b0, range_q};
	assign rem_sub = rem_sh - {1'b0, range_q};
	assign q_bit   = rem_ge;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmi_pkg::ST_IDLE: begin
				if (bar_acc) begin
					state_d = cmi_pkg::ST_START;
				end
			end
			cmi_pkg::ST_START: begin
				if (hist_ready && (window_q != '0)) begin
					state_d = cmi_pkg::ST_WALK;
				end else begin
					state_d = cmi_pkg::ST_DONE;
				end
			end
			cmi_pkg::ST_WALK: begin
				if (!issue && !pend_q) begin
					state_d = cmi_pkg::ST_CHECK;
				end
			end
			cmi_pkg::ST_CHECK: begin
				if (range_pos) begin
					state_d = cmi_pkg::ST_MUL;
				end else begin
					state_d = cmi_pkg::ST_DONE;
				end
			end
			cmi_pkg::ST_MUL: begin
				state_d = cmi_pkg::ST_SAT;
			end
			cmi_pkg::ST_SAT: begin
				if (sat) begin
					state_d = cmi_pkg::ST_DONE;
				end else begin
					state_d = cmi_pkg::ST_DIV;
				end
			end
			cmi_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = cmi_pkg::ST_DONE;
				end
			end
			cmi_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = cmi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cmi_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		bar_ready = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			cmi_pkg::ST_IDLE: begin
				bar_ready = 1'b1;
			end
			cmi_pkg::ST_WALK: begin
				issue = iss_age_q <= {1'b0, window_q};
			end
			cmi_pkg::ST_DONE: begin
				out_load = !result_valid_q || result_ready;
			end
			default: begin
				bar_ready = 1'b0;
			end
		endcase
	end

	assign bar_acc = bar_valid && bar_ready;

	// Register port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == cmi_pkg::REG_WINDOW);
	assign prdata = (paddr[2:2] == cmi_pkg::REG_WINDOW) ?
		{{(cmi_pkg::CFG_DATA_BITS-WB){1'b0}}, window_q} : '0;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= cmi_pkg::ST_IDLE;
			window_q       <= cmi_pkg::WINDOW_RESET;
			wr_slot_q      <= '0;
			rd_ptr_q       <= '0;
			bars_seen_q    <= '0;
			iss_age_q      <= '0;
			pend_q         <= 1'b0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				window_q <= pwdata[WB-1:0];
			end
			// Ring write pointer advances on each request; the fill count advances until it reaches the ring depth.
			if (bar_acc) begin
				wr_slot_q <= (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
				rd_ptr_q  <= (wr_slot_q == '0) ? LAST_SLOT : wr_slot_q - 1'b1;
				iss_age_q <= (WB+1)'(1);
				if (bars_seen_q != CW'(HISTORY_DEPTH)) begin
					bars_seen_q <= bars_seen_q + 1'b1;
				end
			end
			// History walk, one older slot per cycle.
			pend_q <= issue;
			if (issue) begin
				iss_age_q <= iss_age_q + 1'b1;
				rd_ptr_q  <= (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - 1'b1;
			end
			if (state_q == cmi_pkg::ST_SAT) begin
				cnt_q <= '0;
			end else if (state_q == cmi_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// Result register toward the consumer.
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		pend_age_q <= iss_age_q[WB-1:0];
		if (bar_acc) begin
			hh_q   <= bar.bar_high[SW-1:0];
			ll_q   <= bar.bar_low[SW-1:0];
			cnow_q <= bar.bar_close[SW-1:0];
		end
		case (state_q)
			cmi_pkg::ST_START: begin
				res_idx_q <= '0;
				res_rdy_q <= hist_ready;
			end
			cmi_pkg::ST_WALK: begin
				// Fold in the bar read last cycle.
				if (pend_q) begin
					if (pend_age_q == window_q) begin
						cold_q <= rd_close;
					end else begin
						if (rd_high > hh_q) begin
							hh_q <= rd_high;
						end
						if (rd_low < ll_q) begin
							ll_q <= rd_low;
						end
					end
				end
			end
			cmi_pkg::ST_CHECK: begin
				range_q <= hh_q - ll_q;
				diff_q  <= (cnow_q >= cold_q) ? cnow_q - cold_q : cold_q - cnow_q;
			end
			cmi_pkg::ST_MUL: begin
				num_q <= NW'(diff_q) * NW'(cmi_pkg::SCALE_NUM);
			end
			cmi_pkg::ST_SAT: begin
				res_idx_q <= cmi_pkg::INDEX_MAX;
				rem_q     <= num_q[NW-1:IB];
				quo_q     <= num_q[IB-1:0];
			end
			cmi_pkg::ST_DIV: begin
				rem_q <= rem_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
				quo_q <= {quo_q[IB-2:0], q_bit};
				if (div_last) begin
					res_idx_q <= {quo_q[IB-2:0], q_bit};
				end
			end
			default: begin
				res_rdy_q <= res_rdy_q;
			end
		endcase
		if (out_load) begin
			result_q.index_value <= res_idx_q;
			result_q.ready_res   <= res_rdy_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// A nonzero index is only ever reported with ready_res set.
	a_idx_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.index_value != '0)) |-> result.ready_res)
		else $error("nonzero index without ready_res");

	// Only one bar is in flight: no request is taken in the cycle after one.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(bar_valid && bar_ready) |=> !bar_ready)
		else $error("request taken while a bar is in flight");

	// The history walk never reads past the lookback close.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (iss_age_q <= {1'b0, window_q}) && (iss_age_q != '0))
		else $error("history walk out of range");

	// The fill count never passes the ring depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bars_seen_q) <= 32'(HISTORY_DEPTH))
		else $error("fill count beyond ring depth");
`endif

endmodule
